// ===== hw/rtl/lrupr_pkg.sv =====
// Shared constants for the LRU page replacement block.
// No dependencies; imported by the top level.
`default_nettype none

package lrupr_pkg;

   localparam int LRUPR_MAX_FRAMES = 16;
   localparam int LRUPR_PAGE_BITS  = 16;
   localparam int LRUPR_AGE_BITS   = 16;

   localparam int LRUPR_SLOTS_W    = 5;
   localparam int LRUPR_PAGE_W     = 16;
   localparam int LRUPR_SLOT_W     = 4;
   localparam int LRUPR_CSR_AW     = 3;
   localparam int LRUPR_CSR_DW     = 32;

   localparam logic [LRUPR_SLOTS_W-1:0] LRUPR_SLOTS_RESET = 5'd4;
   localparam logic                     LRUPR_REG_SLOTS   = 1'b0;

endpackage

`default_nettype wire

// ===== hw/rtl/lrupr_cell.sv =====
// One frame of the resident set: page tag, age counter, and one stage of the search chain.
// Uses the carry and command types handed down from the top level.
`default_nettype none

module lrupr_cell #(
   parameter int  CELL_IDX   = 0,
   parameter int  IDX_W      = 4,
   parameter int  CNT_W      = 5,
   parameter int  PAGE_BITS  = 16,
   parameter int  AGE_BITS   = 16,
   parameter type carry_type = logic,
   parameter type cmd_type   = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      tok_i,
   input  carry_type carry_i,
   output logic      tok_o,
   output carry_type carry_o
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [AGE_BITS-1:0]  age_ff, age_in;
   logic                 tok_ff;
   carry_type            carry_ff, carry_in;
   logic                 occupied;
   logic                 is_slot;

   assign occupied = CNT_W'(CELL_IDX) < cmd.used;
   assign is_slot  = IDX_W'(CELL_IDX) == cmd.slot;

   always_comb begin
      carry_in = carry_i;
      if (occupied && !carry_i.found && page_ff == cmd.key) begin
         carry_in.found   = 1'b1;
         carry_in.hit_idx = IDX_W'(CELL_IDX);
      end
      if (occupied && (!carry_i.best_any || age_ff > carry_i.best_age)) begin
         carry_in.best_any  = 1'b1;
         carry_in.best_age  = age_ff;
         carry_in.best_idx  = IDX_W'(CELL_IDX);
         carry_in.best_page = page_ff;
      end
   end

   always_comb begin
      page_in = page_ff;
      age_in  = age_ff;
      if (cmd.upd) begin
         if (is_slot) begin
            age_in = '0;
            if (cmd.wr_page) begin
               page_in = cmd.key;
            end
         end else if (CNT_W'(CELL_IDX) < cmd.used_new && age_ff != '1) begin
            age_in = age_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
         age_ff <= '0;
      end else begin
         tok_ff <= tok_i;
         age_ff <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      carry_ff <= carry_in;
   end

   assign tok_o   = tok_ff;
   assign carry_o = carry_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lru_page_replacement.sv =====
// LRU page replacement top level: handshakes, register port, sequencer and the chain of frame cells.
// Depends on lrupr_pkg and lrupr_cell.
//
// Each request word carries one page reference. A search token walks the chain of
// MAX_FRAMES frame cells, one cell per cycle, collecting the lowest matching frame and
// the oldest occupied frame; the decide state then picks the result and updates the cells.
// A new request is accepted only back in the idle state, after the previous one is done;
// the decide state waits while a finished response word is still held and rsp_ready is low.
// The set size register (byte address 0) clamps to 1..MAX_FRAMES and should be written
// only while the block is idle; shrinking it drops the frames above the new size.
`default_nettype none

module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int MAX_FRAMES = LRUPR_MAX_FRAMES,
   parameter int PAGE_BITS  = LRUPR_PAGE_BITS,
   parameter int AGE_BITS   = LRUPR_AGE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [LRUPR_PAGE_W-1:0]  req_page_number,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic [LRUPR_SLOT_W-1:0]  rsp_slot,
   output logic                     rsp_evicted,
   output logic [LRUPR_PAGE_W-1:0]  rsp_evicted_page,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [LRUPR_CSR_AW-1:0]  paddr,
   input  logic [LRUPR_CSR_DW-1:0]  pwdata,
   output logic [LRUPR_CSR_DW-1:0]  prdata,
   output logic                     pready
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SZ_W  = (CNT_W > LRUPR_SLOTS_W) ? CNT_W : LRUPR_SLOTS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   typedef struct packed {
      logic                 found;
      logic [IDX_W-1:0]     hit_idx;
      logic                 best_any;
      logic [AGE_BITS-1:0]  best_age;
      logic [IDX_W-1:0]     best_idx;
      logic [PAGE_BITS-1:0] best_page;
   } carry_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0] key;
      logic [CNT_W-1:0]     used;
      logic                 upd;
      logic [IDX_W-1:0]     slot;
      logic                 wr_page;
      logic [CNT_W-1:0]     used_new;
   } cmd_type;

   function automatic logic [CNT_W-1:0] clamp_size(input logic [LRUPR_SLOTS_W-1:0] v);
      logic [SZ_W-1:0] ext;
      ext = SZ_W'(v);
      if (ext == '0) begin
         clamp_size = CNT_W'(1);
      end else if (ext > SZ_W'(MAX_FRAMES)) begin
         clamp_size = CNT_W'(MAX_FRAMES);
      end else begin
         clamp_size = CNT_W'(ext);
      end
   endfunction

   logic [1:0]               state_ff, state_in;
   logic [LRUPR_SLOTS_W-1:0] slots_ff, slots_in;
   logic [CNT_W-1:0]         filled_ff, filled_in;
   logic [PAGE_BITS-1:0]     key_ff, key_in;
   logic                     start_ff, start_in;
   carry_type                res_ff, res_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [LRUPR_SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;
   logic [LRUPR_PAGE_W-1:0]  rsp_evicted_page_ff, rsp_evicted_page_in;

   logic                     tok [0:MAX_FRAMES];
   carry_type                carry [0:MAX_FRAMES];
   cmd_type                  cmd;

   logic [CNT_W-1:0]         size_w;
   logic [CNT_W-1:0]         used_w;
   logic                     csr_wr;
   logic                     req_acc;
   logic                     rsp_free;
   logic                     evict_w;

   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite && pready && paddr[2] == LRUPR_REG_SLOTS;
   assign prdata   = (paddr[2] == LRUPR_REG_SLOTS) ? LRUPR_CSR_DW'(slots_ff) : '0;
   assign req_ready = state_ff == S_IDLE;
   assign req_acc  = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign size_w = clamp_size(slots_ff);
   assign used_w = (filled_ff > size_w) ? size_w : filled_ff;

   // decide slot and eviction from the collected chain result
   always_comb begin
      cmd          = '0;
      cmd.key      = key_ff;
      cmd.used     = used_w;
      cmd.upd      = state_ff == S_DECIDE && rsp_free;
      cmd.used_new = used_w;
      evict_w      = 1'b0;
      if (res_ff.found) begin
         cmd.slot = res_ff.hit_idx;
      end else if (used_w < size_w) begin
         cmd.slot     = IDX_W'(used_w);
         cmd.wr_page  = 1'b1;
         cmd.used_new = used_w + 1'b1;
      end else begin
         cmd.slot    = res_ff.best_idx;
         cmd.wr_page = 1'b1;
         evict_w     = 1'b1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      slots_in  = slots_ff;
      filled_in = filled_ff;
      key_in    = key_ff;
      start_in  = 1'b0;
      res_in    = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               key_in   = PAGE_BITS'(req_page_number);
               start_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[MAX_FRAMES]) begin
               res_in   = carry[MAX_FRAMES];
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cmd.upd) begin
               filled_in = cmd.used_new;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_wr) begin
         slots_in = pwdata[LRUPR_SLOTS_W-1:0];
         if (filled_ff > clamp_size(pwdata[LRUPR_SLOTS_W-1:0])) begin
            filled_in = clamp_size(pwdata[LRUPR_SLOTS_W-1:0]);
         end
      end
   end

   always_comb begin
      rsp_valid_in        = rsp_valid_ff;
      rsp_hit_in          = rsp_hit_ff;
      rsp_slot_in         = rsp_slot_ff;
      rsp_evicted_in      = rsp_evicted_ff;
      rsp_evicted_page_in = rsp_evicted_page_ff;
      priority if (cmd.upd) begin
         rsp_valid_in        = 1'b1;
         rsp_hit_in          = res_ff.found;
         rsp_slot_in         = LRUPR_SLOT_W'(cmd.slot);
         rsp_evicted_in      = evict_w;
         rsp_evicted_page_in = evict_w ? LRUPR_PAGE_W'(res_ff.best_page) : '0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slots_ff     <= LRUPR_SLOTS_RESET;
         filled_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         filled_ff    <= filled_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff              <= key_in;
      res_ff              <= res_in;
      rsp_hit_ff          <= rsp_hit_in;
      rsp_slot_ff         <= rsp_slot_in;
      rsp_evicted_ff      <= rsp_evicted_in;
      rsp_evicted_page_ff <= rsp_evicted_page_in;
   end

   assign tok[0]   = start_ff;
   assign carry[0] = '0;

   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      lrupr_cell #(
         .CELL_IDX   (g),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .PAGE_BITS  (PAGE_BITS),
         .AGE_BITS   (AGE_BITS),
         .carry_type (carry_type),
         .cmd_type   (cmd_type)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .tok_i   (tok[g]),
         .carry_i (carry[g]),
         .tok_o   (tok[g+1]),
         .carry_o (carry[g+1])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

   a_tok_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok[MAX_FRAMES] |-> state_ff == S_SCAN)
      else $error("search token left the chain outside the scan state");

   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= size_w)
      else $error("occupied frame count exceeds set size");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hit_ff |-> !rsp_evicted_ff && rsp_evicted_page_ff == '0)
      else $error("hit word reports an eviction");

   a_upd_result: assert property (@(posedge clock) disable iff (reset)
      cmd.upd |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("frame update without a response word");

endmodule

`default_nettype wire
